[design/bdeq_pkg.sv]
`timescale 1ns / 1ps

package bdeq_pkg;

  localparam int unsigned Depth      = 1024;
  localparam int unsigned AddrWidth  = $clog2(Depth);
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned CountWidth = 11;
  localparam int unsigned OutWidth   = 17;

  typedef logic [AddrWidth-1:0]  addr_t;
  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LOOK       = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD_F = 4'b0010,
    S_RD_R = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  localparam count_t CapReset = count_t'(1024);
  localparam count_t CapMax   = count_t'(Depth);

endpackage

[design/bounded_double_ended_queue.sv]
`timescale 1ns / 1ps

// Bounded deque on a 1024-entry ring buffer. Each accepted item (push front,
// push rear, pop front, pop rear or look) returns one result with the success
// flag, the front and rear values after the operation (-1 when empty) and the
// empty and full flags. On acceptance the pointer update and any write are
// applied, then the front and the rear entries are read one after the other
// through the single read port of the entry RAM. The result sits in an output
// register, so the next item is accepted as soon as the result is loaded; a
// result still waiting when the next one is ready holds the engine until it
// is taken.
// capacity_limit (reset 1024) is clamped to 1024; a write leaves the contents
// unchanged.

module bounded_double_ended_queue (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [bdeq_pkg::CountWidth-1:0]         cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [2:0]                              op_i,
  input  logic [bdeq_pkg::ValueWidth-1:0]         push_value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    ok_o,
  output logic signed [bdeq_pkg::OutWidth-1:0]    front_value_o,
  output logic signed [bdeq_pkg::OutWidth-1:0]    rear_value_o,
  output logic                                    is_empty_o,
  output logic                                    is_full_o
);

  bdeq_pkg::state_e state_q, state_d;
  bdeq_pkg::addr_t  front_q, front_d;
  bdeq_pkg::addr_t  rear_q, rear_d;
  bdeq_pkg::count_t count_q, count_d;
  bdeq_pkg::count_t cap_q;
  bdeq_pkg::count_t cap_eff;
  logic             ok_q, ok_d;
  bdeq_pkg::value_t front_data_q;

  logic             out_valid_q;
  logic             res_ok_q;
  logic signed [bdeq_pkg::OutWidth-1:0] res_front_q, res_rear_q;
  logic             res_empty_q, res_full_q;

  logic             accept;
  logic             full;
  logic             load;
  logic             we;
  bdeq_pkg::addr_t  waddr;
  logic             re;
  bdeq_pkg::addr_t  raddr;
  bdeq_pkg::value_t rdata;

  assign cap_eff    = (cap_q > bdeq_pkg::CapMax) ? bdeq_pkg::CapMax : cap_q;
  assign full       = (count_q >= cap_eff);
  assign in_ready_o = (state_q == bdeq_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q == bdeq_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    front_d = front_q;
    rear_d  = rear_q;
    count_d = count_q;
    ok_d    = ok_q;
    we      = 1'b0;
    waddr   = rear_q;
    re      = 1'b0;
    raddr   = front_q;
    unique case (state_q)
      bdeq_pkg::S_IDLE: begin
        if (accept) begin
          ok_d    = 1'b1;
          state_d = bdeq_pkg::S_RD_F;
          case (op_i)
            bdeq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                ok_d = 1'b0;
              end else begin
                front_d = front_q - bdeq_pkg::addr_t'(1);
                waddr   = front_d;
                we      = 1'b1;
                count_d = count_q + bdeq_pkg::count_t'(1);
              end
            end
            bdeq_pkg::OP_PUSH_REAR: begin
              if (full) begin
                ok_d = 1'b0;
              end else begin
                waddr   = rear_q;
                we      = 1'b1;
                rear_d  = rear_q + bdeq_pkg::addr_t'(1);
                count_d = count_q + bdeq_pkg::count_t'(1);
              end
            end
            bdeq_pkg::OP_POP_FRONT: begin
              if (count_q == '0) begin
                ok_d = 1'b0;
              end else begin
                front_d = front_q + bdeq_pkg::addr_t'(1);
                count_d = count_q - bdeq_pkg::count_t'(1);
              end
            end
            bdeq_pkg::OP_POP_REAR: begin
              if (count_q == '0) begin
                ok_d = 1'b0;
              end else begin
                rear_d  = rear_q - bdeq_pkg::addr_t'(1);
                count_d = count_q - bdeq_pkg::count_t'(1);
              end
            end
            default: begin
              // look only, unused codes included
            end
          endcase
        end
      end
      bdeq_pkg::S_RD_F: begin
        re      = 1'b1;
        raddr   = front_q;
        state_d = bdeq_pkg::S_RD_R;
      end
      bdeq_pkg::S_RD_R: begin
        re      = 1'b1;
        raddr   = rear_q - bdeq_pkg::addr_t'(1);
        state_d = bdeq_pkg::S_DONE;
      end
      bdeq_pkg::S_DONE: begin
        // hold until the output register frees up
        if (load) begin
          state_d = bdeq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bdeq_pkg::S_IDLE;
      end
    endcase
  end

  bdeq_ram #(
    .WIDTH(bdeq_pkg::ValueWidth),
    .DEPTH(bdeq_pkg::Depth)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(push_value_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdeq_pkg::S_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      count_q     <= '0;
      ok_q        <= 1'b0;
      cap_q       <= bdeq_pkg::CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bdeq_pkg::S_RD_R) begin
      front_data_q <= rdata;
    end
    if (load) begin
      res_ok_q    <= ok_q;
      res_empty_q <= (count_q == '0);
      res_full_q  <= full;
      if (count_q == '0) begin
        res_front_q <= '1;
        res_rear_q  <= '1;
      end else begin
        res_front_q <= {1'b0, front_data_q};
        res_rear_q  <= {1'b0, rdata};
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = res_ok_q;
  assign front_value_o = res_front_q;
  assign rear_value_o  = res_rear_q;
  assign is_empty_o    = res_empty_q;
  assign is_full_o     = res_full_q;

endmodule

[design/bdeq_ram.sv]
`timescale 1ns / 1ps

module bdeq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sim/tb_bounded_double_ended_queue.sv]
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue;

  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportLimit  = 10;

  // Codes above OP_LOOK are spare and behave as a look.
  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareLast  = 3'd7;

  // -1 at the output width marks an empty deque.
  localparam logic [bdeq_pkg::OutWidth-1:0] EmptyMark = '1;

  typedef struct packed {
    logic [2:0]       op;
    bdeq_pkg::value_t value;
  } deque_req_t;

  typedef struct packed {
    logic                          ok;
    logic [bdeq_pkg::OutWidth-1:0] front;
    logic [bdeq_pkg::OutWidth-1:0] rear;
    logic                          empty;
    logic                          full;
  } deque_view_t;

  logic                                 clk_i        = 1'b0;
  logic                                 rst_ni       = 1'b0;
  logic                                 cfg_we_i     = 1'b0;
  logic [bdeq_pkg::CountWidth-1:0]      cfg_wdata_i  = '0;
  logic                                 in_valid_i   = 1'b0;
  logic                                 in_ready_o;
  logic [2:0]                           op_i         = bdeq_pkg::OP_LOOK;
  bdeq_pkg::value_t                     push_value_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i  = 1'b0;
  logic                                 ok_o;
  logic signed [bdeq_pkg::OutWidth-1:0] front_value_o;
  logic signed [bdeq_pkg::OutWidth-1:0] rear_value_o;
  logic                                 is_empty_o;
  logic                                 is_full_o;

  bounded_double_ended_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  // Shadow deque
  bdeq_pkg::value_t slot_mem [bdeq_pkg::Depth];
  bdeq_pkg::addr_t  head_slot = '0;
  bdeq_pkg::addr_t  tail_slot = '0;
  int               live_count = 0;
  bdeq_pkg::count_t capacity = bdeq_pkg::CapReset;

  deque_req_t  pending_items[$];
  deque_view_t expected_views[$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic deque_view_t apply_deque_op(logic [2:0] op, bdeq_pkg::value_t value);
    deque_view_t view;
    int          limit;
    limit   = (capacity > bdeq_pkg::CapMax) ? int'(bdeq_pkg::CapMax) : int'(capacity);
    view.ok = 1'b1;
    case (op)
      bdeq_pkg::OP_PUSH_FRONT: begin
        if (live_count >= limit) view.ok = 1'b0;
        else begin
          head_slot = head_slot - bdeq_pkg::addr_t'(1);
          slot_mem[head_slot] = value;
          live_count++;
        end
      end
      bdeq_pkg::OP_PUSH_REAR: begin
        if (live_count >= limit) view.ok = 1'b0;
        else begin
          slot_mem[tail_slot] = value;
          tail_slot = tail_slot + bdeq_pkg::addr_t'(1);
          live_count++;
        end
      end
      bdeq_pkg::OP_POP_FRONT: begin
        if (live_count == 0) view.ok = 1'b0;
        else begin
          head_slot = head_slot + bdeq_pkg::addr_t'(1);
          live_count--;
        end
      end
      bdeq_pkg::OP_POP_REAR: begin
        if (live_count == 0) view.ok = 1'b0;
        else begin
          tail_slot = tail_slot - bdeq_pkg::addr_t'(1);
          live_count--;
        end
      end
      default: ;
    endcase
    if (live_count == 0) begin
      view.front = EmptyMark;
      view.rear  = EmptyMark;
      view.empty = 1'b1;
    end else begin
      view.front = {1'b0, slot_mem[head_slot]};
      view.rear  = {1'b0, slot_mem[tail_slot - bdeq_pkg::addr_t'(1)]};
      view.empty = 1'b0;
    end
    view.full = (live_count >= limit);
    return view;
  endfunction

  // Driver: predict on acceptance, then load the next item or go idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_views.push_back(apply_deque_op(op_i, push_value_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          op_i         <= pending_items[0].op;
          push_value_i <= pending_items[0].value;
          void'(pending_items.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    deque_view_t want;
    deque_view_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{ok_o, front_value_o, rear_value_o, is_empty_o, is_full_o};
        if (expected_views.size() == 0) begin
          if (mismatch_count < ReportLimit)
            $display("%0t: result with nothing expected: ok=%0b front=%0d rear=%0d e=%0b f=%0b",
                     $realtime, got.ok, $signed(got.front), $signed(got.rear), got.empty,
                     got.full);
          mismatch_count++;
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            if (mismatch_count < ReportLimit)
              $display({"%0t: expected ok=%0b front=%0d rear=%0d e=%0b f=%0b, ",
                        "got ok=%0b front=%0d rear=%0d e=%0b f=%0b"},
                       $realtime, want.ok, $signed(want.front), $signed(want.rear),
                       want.empty, want.full, got.ok, $signed(got.front),
                       $signed(got.rear), got.empty, got.full);
            mismatch_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when no item moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("tb_bounded_double_ended_queue NOT OK");
        $finish;
      end
    end
  end

  task automatic add_item(logic [2:0] op, bdeq_pkg::value_t value);
    pending_items.push_back('{op, value});
  endtask

  task automatic add_random(int count, int push_pct);
    logic [2:0]       op;
    bdeq_pkg::value_t value;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 6) op = 3'($urandom_range(bdeq_pkg::OP_LOOK, OpSpareLast));
      else if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? bdeq_pkg::OP_PUSH_REAR : bdeq_pkg::OP_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? bdeq_pkg::OP_POP_REAR : bdeq_pkg::OP_POP_FRONT;
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = '1;
        default: value = bdeq_pkg::value_t'($urandom);
      endcase
      add_item(op, value);
    end
  endtask

  task automatic drain_all();
    while (pending_items.size() != 0 || in_valid_i || expected_views.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Wait for idle, write the capacity and set the idling of the next phase.
  task automatic begin_phase(bdeq_pkg::count_t cap, int send_pct, int recv_pct);
    drain_all();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    capacity       = cap;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty deque, spare codes, both ends at the value extremes
    add_item(bdeq_pkg::OP_LOOK, '0);
    add_item(bdeq_pkg::OP_POP_FRONT, '0);
    add_item(bdeq_pkg::OP_POP_REAR, '1);
    add_item(OpSpareFirst, '1);
    add_item(OpSpareLast, '0);
    add_item(bdeq_pkg::OP_PUSH_FRONT, 16'hFFFF);
    add_item(bdeq_pkg::OP_PUSH_REAR, 16'h0000);
    add_item(bdeq_pkg::OP_PUSH_FRONT, 16'h5555);
    add_item(bdeq_pkg::OP_PUSH_REAR, 16'hAAAA);
    add_item(bdeq_pkg::OP_POP_FRONT, '0);
    add_item(bdeq_pkg::OP_POP_REAR, '0);
    add_item(bdeq_pkg::OP_POP_FRONT, '0);
    add_item(bdeq_pkg::OP_POP_REAR, '0);
    add_item(bdeq_pkg::OP_POP_FRONT, '0);

    // zero capacity: every push fails, empty reads full too
    begin_phase(bdeq_pkg::count_t'(0), 0, 0);
    add_item(bdeq_pkg::OP_PUSH_FRONT, 16'h0001);
    add_item(bdeq_pkg::OP_PUSH_REAR, 16'h0002);
    add_item(bdeq_pkg::OP_LOOK, '0);

    begin_phase(bdeq_pkg::count_t'(1), 0, 0);
    add_item(bdeq_pkg::OP_PUSH_REAR, 16'h1234);
    add_item(bdeq_pkg::OP_PUSH_FRONT, 16'h4321);
    add_item(bdeq_pkg::OP_POP_FRONT, '0);

    // capacity above the store acts as the store size
    begin_phase(bdeq_pkg::count_t'(2047), 0, 0);
    add_item(bdeq_pkg::OP_PUSH_REAR, 16'h00FF);
    add_item(bdeq_pkg::OP_PUSH_REAR, 16'hFF00);
    add_item(bdeq_pkg::OP_PUSH_FRONT, 16'h8001);

    // capacity lowered below the count: keep entries, refuse pushes
    begin_phase(bdeq_pkg::count_t'(2), 0, 0);
    add_item(bdeq_pkg::OP_LOOK, '0);
    add_item(bdeq_pkg::OP_PUSH_REAR, 16'h7777);
    add_item(bdeq_pkg::OP_POP_REAR, '0);

    begin_phase(bdeq_pkg::count_t'(3), 86, 0);
    add_random(60, 50);
    begin_phase(bdeq_pkg::count_t'(1), 0, 86);
    add_random(50, 50);
    begin_phase(bdeq_pkg::count_t'(17), 30, 30);
    add_random(80, 55);

    // fill the whole store from both ends, wrapping both pointers
    begin_phase(bdeq_pkg::count_t'(1500), 30, 30);
    for (int i = 0; i < int'(bdeq_pkg::Depth) + 6; i++)
      add_item($urandom_range(0, 3) != 0 ? bdeq_pkg::OP_PUSH_REAR : bdeq_pkg::OP_PUSH_FRONT,
               bdeq_pkg::value_t'($urandom));

    begin_phase(bdeq_pkg::count_t'(4), 0, 86);
    add_random(60, 40);
    begin_phase(bdeq_pkg::count_t'(0), 86, 0);
    add_random(40, 50);
    begin_phase(bdeq_pkg::CapReset, 0, 0);
    add_random(40, 50);

    drain_all();
    if (mismatch_count == 0 && expected_views.size() == 0) begin
      $display("tb_bounded_double_ended_queue OK");
    end else begin
      $display("tb_bounded_double_ended_queue NOT OK");
    end
    $finish;
  end

endmodule

[bounded_double_ended_queue.f]
design/bdeq_pkg.sv
design/bdeq_ram.sv
design/bounded_double_ended_queue.sv
sim/tb_bounded_double_ended_queue.sv
